/* rtl/pfp_pkg.sv */
package pfp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int NORM_W   = 32;
  localparam int OFFSET_W = 48;
  localparam int MAG_W    = 31;
  localparam int SUM_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int QUO_W    = 62;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } comp_t;

endpackage

/* rtl/pfp_isqrt.sv */
module pfp_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  logic [pfp_pkg::SUM_W-1:0] x,
  output logic                      out_vld,
  output logic [pfp_pkg::ROOT_W-1:0] root
);
  import pfp_pkg::*;

  localparam int STEPS = ROOT_W;

  logic                       vld_r  [STEPS];
  logic [SUM_W-1:0]           rem_r  [STEPS];
  logic [ROOT_W-1:0]          res_r  [STEPS];

  // one root bit per stage, highest first
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic             vld_c;
    logic [SUM_W-1:0] rem_c;
    logic [ROOT_W-1:0] res_c;
    logic [SUM_W+1:0] trial;
    logic [SUM_W-1:0] rem_nxt;
    logic [ROOT_W-1:0] res_nxt;
    logic [SUM_W+1:0] rem_ext;
    logic [SUM_W+1:0] bitv;
    localparam int SH = 2 * (STEPS - 1 - k);
    if (k == 0) begin : g_first
      assign vld_c = in_vld;
      assign rem_c = x;
      assign res_c = '0;
    end else begin : g_next
      assign vld_c = vld_r[k-1];
      assign rem_c = rem_r[k-1];
      assign res_c = res_r[k-1];
    end
    assign bitv    = ({{(SUM_W+1){1'b0}}, 1'b1} << SH);
    assign rem_ext = {2'b00, rem_c};
    assign trial   = ({{(SUM_W+2-ROOT_W){1'b0}}, res_c} << (STEPS - k)) | bitv;
    always_comb begin
      if (rem_ext >= trial) begin
        rem_nxt = SUM_W'(rem_ext - trial);
        res_nxt = res_c | (ROOT_W'(1) << (STEPS - 1 - k));
      end else begin
        rem_nxt = rem_c;
        res_nxt = res_c;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_c;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= rem_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign out_vld = vld_r[STEPS-1];
  assign root    = res_r[STEPS-1];

endmodule

/* rtl/pfp_divider.sv */
module pfp_divider #(
  parameter int TAG_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  logic [pfp_pkg::QUO_W-1:0]  num,
  input  logic [pfp_pkg::ROOT_W-1:0] den,
  input  logic [TAG_W-1:0]           tag_in,
  output logic                       out_vld,
  output logic [pfp_pkg::QUO_W-1:0]  quo,
  output logic [TAG_W-1:0]           tag_out
);
  import pfp_pkg::*;

  localparam int STEPS = QUO_W;

  logic               vld_r [STEPS];
  logic [QUO_W-1:0]   num_r [STEPS];
  logic [ROOT_W:0]    rem_r [STEPS];
  logic [ROOT_W-1:0]  den_r [STEPS];
  logic [TAG_W-1:0]   tag_r [STEPS];

  // restoring division, one quotient bit per stage; quotient shifts into num
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic              vld_c;
    logic [QUO_W-1:0]  num_c;
    logic [ROOT_W:0]   rem_c;
    logic [ROOT_W-1:0] den_c;
    logic [TAG_W-1:0]  tag_c;
    logic [ROOT_W+1:0] sh;
    logic [ROOT_W+1:0] dif;
    logic [ROOT_W:0]   rem_nxt;
    logic [QUO_W-1:0]  num_nxt;
    if (k == 0) begin : g_first
      assign vld_c = in_vld;
      assign num_c = num;
      assign rem_c = '0;
      assign den_c = den;
      assign tag_c = tag_in;
    end else begin : g_next
      assign vld_c = vld_r[k-1];
      assign num_c = num_r[k-1];
      assign rem_c = rem_r[k-1];
      assign den_c = den_r[k-1];
      assign tag_c = tag_r[k-1];
    end
    assign sh  = {rem_c, num_c[QUO_W-1]};
    assign dif = sh - {2'b00, den_c};
    always_comb begin
      if (!dif[ROOT_W+1]) begin
        rem_nxt = dif[ROOT_W:0];
        num_nxt = {num_c[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[ROOT_W:0];
        num_nxt = {num_c[QUO_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_c;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[k] <= num_nxt;
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_c;
        tag_r[k] <= tag_c;
      end
    end
  end

  assign out_vld = vld_r[STEPS-1];
  assign quo     = num_r[STEPS-1];
  assign tag_out = tag_r[STEPS-1];

endmodule

/* rtl/plane_from_three_points.sv */
// Pipeline: an accepted request passes to its result at the output register
// through a 32-stage square root, 62-stage divider and 9 arithmetic stages.
// Throughput: one request per cycle; the whole pipeline advances together,
// and out_stall holds every stage (the output register only frees when taken).
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
module plane_from_three_points #(
  parameter int COORD_WIDTH = pfp_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_p1_x,
  input  logic signed [COORD_WIDTH-1:0] in_p1_y,
  input  logic signed [COORD_WIDTH-1:0] in_p1_z,
  input  logic signed [COORD_WIDTH-1:0] in_p2_x,
  input  logic signed [COORD_WIDTH-1:0] in_p2_y,
  input  logic signed [COORD_WIDTH-1:0] in_p2_z,
  input  logic signed [COORD_WIDTH-1:0] in_p3_x,
  input  logic signed [COORD_WIDTH-1:0] in_p3_y,
  input  logic signed [COORD_WIDTH-1:0] in_p3_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [pfp_pkg::NORM_W-1:0]   out_norm_x,
  output logic signed [pfp_pkg::NORM_W-1:0]   out_norm_y,
  output logic signed [pfp_pkg::NORM_W-1:0]   out_norm_z,
  output logic signed [pfp_pkg::OFFSET_W-1:0] out_offset,
  output logic                          out_degenerate
);
  import pfp_pkg::*;

  localparam int DW = COORD_WIDTH + 1;        // edge width
  localparam int PW = 2 * DW;                 // product width
  localparam int CW = PW + 1;                 // cross component width
  localparam int LW = $clog2(CW + 1);         // bit length width
  localparam int NW = 32;                     // q width incl sign
  localparam int TW = NW + COORD_WIDTH;       // partial product of offset
  localparam int AW = TW + 2;                 // offset sum
  localparam int SQRT_LAT = ROOT_W;
  localparam int TAG_W = 3 * MAG_W + 3 + 3 * COORD_WIDTH + 1;

  // The whole pipeline moves as one: stall only while the output is held.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---- stage 1: edges --------------------------------------------------
  logic                       v1_r;
  logic signed [DW-1:0]       ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [COORD_WIDTH-1:0] p1x_r, p1y_r, p1z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r  <= DW'(in_p2_x) - DW'(in_p1_x);
      ay_r  <= DW'(in_p2_y) - DW'(in_p1_y);
      az_r  <= DW'(in_p2_z) - DW'(in_p1_z);
      bx_r  <= DW'(in_p3_x) - DW'(in_p1_x);
      by_r  <= DW'(in_p3_y) - DW'(in_p1_y);
      bz_r  <= DW'(in_p3_z) - DW'(in_p1_z);
      p1x_r <= in_p1_x;
      p1y_r <= in_p1_y;
      p1z_r <= in_p1_z;
    end
  end

  // ---- stage 2: six products -------------------------------------------
  logic                 v2_r;
  logic signed [PW-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [COORD_WIDTH-1:0] p1x2_r, p1y2_r, p1z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m0_r <= ay_r * bz_r;
      m1_r <= az_r * by_r;
      m2_r <= az_r * bx_r;
      m3_r <= ax_r * bz_r;
      m4_r <= ax_r * by_r;
      m5_r <= ay_r * bx_r;
      p1x2_r <= p1x_r;
      p1y2_r <= p1y_r;
      p1z2_r <= p1z_r;
    end
  end

  // ---- stage 3: cross product as sign and magnitude ---------------------
  logic                 v3_r;
  logic [CW-1:0]        c_mag_r [3];
  logic [2:0]           c_neg_r;
  logic signed [COORD_WIDTH-1:0] p1x3_r, p1y3_r, p1z3_r;
  logic signed [CW-1:0] cr [3];

  assign cr[0] = CW'(m0_r) - CW'(m1_r);
  assign cr[1] = CW'(m2_r) - CW'(m3_r);
  assign cr[2] = CW'(m4_r) - CW'(m5_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c_neg_r[i]    <= cr[i][CW-1];
        c_mag_r[i]    <= cr[i][CW-1] ? CW'(-cr[i]) : CW'(cr[i]);
      end
      p1x3_r <= p1x2_r;
      p1y3_r <= p1y2_r;
      p1z3_r <= p1z2_r;
    end
  end

  // ---- stage 4: common bit length --------------------------------------
  logic                 v4_r;
  logic [CW-1:0]        c_mag4_r [3];
  logic [2:0]           c_neg4_r;
  logic [LW-1:0]        len_r;
  logic signed [COORD_WIDTH-1:0] p1x4_r, p1y4_r, p1z4_r;
  logic [CW-1:0]        orv;
  logic [LW-1:0]        len_nxt;

  assign orv = c_mag_r[0] | c_mag_r[1] | c_mag_r[2];
  always_comb begin
    len_nxt = '0;
    for (int b = 0; b < CW; b++) begin
      if (orv[b]) len_nxt = LW'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_mag4_r <= c_mag_r;
      c_neg4_r <= c_neg_r;
      len_r    <= len_nxt;
      p1x4_r   <= p1x3_r;
      p1y4_r   <= p1y3_r;
      p1z4_r   <= p1z3_r;
    end
  end

  // ---- stage 5: scale the largest magnitude into [2^30, 2^31) ------------
  logic                 v5_r;
  logic [MAG_W-1:0]     sm_r [3];
  logic [2:0]           neg5_r;
  logic                 deg5_r;
  logic signed [COORD_WIDTH-1:0] p1x5_r, p1y5_r, p1z5_r;
  logic [MAG_W-1:0]     sm_nxt [3];
  logic [CW+MAG_W-1:0]  wide [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (len_r > LW'(MAG_W)) begin
        wide[i] = (CW+MAG_W)'(c_mag4_r[i]) >> (len_r - LW'(MAG_W));
      end else begin
        wide[i] = (CW+MAG_W)'(c_mag4_r[i]) << (LW'(MAG_W) - len_r);
      end
      sm_nxt[i] = wide[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sm_r   <= sm_nxt;
      neg5_r <= c_neg4_r;
      deg5_r <= (len_r == '0);
      p1x5_r <= p1x4_r;
      p1y5_r <= p1y4_r;
      p1z5_r <= p1z4_r;
    end
  end

  // ---- stage 6: sum of squares -----------------------------------------
  logic                 v6_r;
  logic [SUM_W-1:0]     sum_r;
  logic [TAG_W-1:0]     tag6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= SUM_W'(sm_r[0]) * SUM_W'(sm_r[0]) + SUM_W'(sm_r[1]) * SUM_W'(sm_r[1])
             + SUM_W'(sm_r[2]) * SUM_W'(sm_r[2]);
      tag6_r <= {sm_r[0], sm_r[1], sm_r[2], neg5_r, p1x5_r, p1y5_r, p1z5_r, deg5_r};
    end
  end

  // ---- square root, tag rides in a matching delay line -----------------
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [TAG_W-1:0]  tdl_r [SQRT_LAT];

  pfp_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (v6_r),
    .x       (sum_r),
    .out_vld (sq_vld),
    .root    (sq_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      tdl_r[0] <= tag6_r;
      for (int k = 1; k < SQRT_LAT; k++) tdl_r[k] <= tdl_r[k-1];
    end
  end

  // ---- three dividers in parallel: round(m * 2^30 / s) -----------------
  logic [MAG_W-1:0] smd [3];
  logic [TAG_W-1:0] tag_s;
  logic [QUO_W-1:0] num [3];
  logic [QUO_W-1:0] quo [3];
  logic [TAG_W-1:0] tag_d [3];
  logic [2:0]       dv;
  logic [ROOT_W-1:0] den;

  assign tag_s  = tdl_r[SQRT_LAT-1];
  assign smd[0] = tag_s[TAG_W-1 -: MAG_W];
  assign smd[1] = tag_s[TAG_W-1-MAG_W -: MAG_W];
  assign smd[2] = tag_s[TAG_W-1-2*MAG_W -: MAG_W];
  // degenerate items carry s = 0; force 1 to keep the divider defined
  assign den    = (sq_root == '0) ? ROOT_W'(1) : sq_root;

  for (genvar i = 0; i < 3; i++) begin : g_div
    assign num[i] = ({smd[i], 30'b0}) + QUO_W'(den >> 1);
    pfp_divider #(.TAG_W(TAG_W)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (sq_vld),
      .num     (num[i]),
      .den     (den),
      .tag_in  (tag_s),
      .out_vld (dv[i]),
      .quo     (quo[i]),
      .tag_out (tag_d[i])
    );
  end

  // ---- stage 7: sign the normal ----------------------------------------
  logic                 v7_r;
  logic signed [NW-1:0] nv_r [3];
  logic signed [COORD_WIDTH-1:0] p7_r [3];
  logic                 deg7_r;
  logic [2:0]           negd;

  assign negd = tag_d[0][3*COORD_WIDTH+3 -: 3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= dv[0];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nv_r[i] <= negd[i] ? -NW'(quo[i][NW-1:0]) : NW'(quo[i][NW-1:0]);
      end
      p7_r[0] <= tag_d[0][3*COORD_WIDTH -: COORD_WIDTH];
      p7_r[1] <= tag_d[0][2*COORD_WIDTH -: COORD_WIDTH];
      p7_r[2] <= tag_d[0][COORD_WIDTH -: COORD_WIDTH];
      deg7_r  <= tag_d[0][0];
    end
  end

  // ---- stage 8: n . p1 partial products --------------------------------
  logic                 v8_r;
  logic signed [TW-1:0] t_r [3];
  logic signed [NW-1:0] nv8_r [3];
  logic                 deg8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (adv) begin
      v8_r <= v7_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) t_r[i] <= TW'(nv_r[i]) * TW'(p7_r[i]);
      nv8_r  <= nv_r;
      deg8_r <= deg7_r;
    end
  end

  // ---- stage 9: negate, round ties up, saturate; output register --------
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] sh;
  logic [OFFSET_W-1:0]  off_nxt;
  localparam logic signed [AW-1:0] OMAX = AW'((64'sd1 <<< (OFFSET_W-1)) - 1);
  localparam logic signed [AW-1:0] OMIN = -AW'(64'sd1 <<< (OFFSET_W-1));

  always_comb begin
    acc = -(AW'(t_r[0]) + AW'(t_r[1]) + AW'(t_r[2])) + AW'(64'sd1 <<< 29);
    sh  = acc >>> 30;
    if (sh > OMAX) begin
      off_nxt = OFFSET_W'(OMAX);
    end else if (sh < OMIN) begin
      off_nxt = OFFSET_W'(OMIN);
    end else begin
      off_nxt = OFFSET_W'(sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v8_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_degenerate <= deg8_r;
      out_norm_x     <= deg8_r ? '0 : nv8_r[0];
      out_norm_y     <= deg8_r ? '0 : nv8_r[1];
      out_norm_z     <= deg8_r ? '0 : nv8_r[2];
      out_offset     <= deg8_r ? '0 : off_nxt;
    end
  end

  // a held result keeps the input stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input not stalled while output held");
  // a degenerate result reports a zero normal
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_norm_x == '0 && out_norm_y == '0
      && out_norm_z == '0 && out_offset == '0))
    else $error("degenerate result not zero");
  // the three dividers stay in lockstep
  assert property (@(posedge clk) disable iff (!rst_n)
    (dv[0] == dv[1]) && (dv[1] == dv[2]))
    else $error("divider lanes out of step");

endmodule
